[src/pf66_pkg.sv]
// Shared types, constants and symbol helpers for the 6x6 Playfair digraph unit.
package pf66_pkg;

   localparam int SIDE   = 6;
   localparam int CELLS  = SIDE * SIDE;
   localparam int CHAR_W = 8;
   localparam int SYM_W  = 6;
   localparam int RC_W   = 3;

   // request kinds carried in req_type
   localparam logic [1:0] REQ_KEY    = 2'd0;
   localparam logic [1:0] REQ_FINISH = 2'd1;
   localparam logic [1:0] REQ_TEXT   = 2'd2;

   // configuration register indexes
   localparam logic CSR_DECRYPT_MODE = 1'b0;
   localparam logic CSR_PAD_CHAR     = 1'b1;

   localparam logic [CHAR_W-1:0] PAD_RESET = 8'd120;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [CHAR_W-1:0] in_char;
      logic              in_last;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_first;
      logic [CHAR_W-1:0] out_second;
      logic              pair_last;
      logic              not_found;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic             req_load;
      logic             key_append;
      logic             fill_append;
      logic [SYM_W-1:0] fill_idx;
      logic             text_decide;
      logic             map_read;
      logic             sq_read;
      logic             emit_load;
      logic             next_pair;
   } pf66_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic text_has_pair;
      logic has_second;
      logic slot_free;
   } pf66_status_type;

   // map a-z to 0..25 and 0-9 to 26..35; top bit flags a valid symbol
   function automatic logic [SYM_W:0] sym_lookup(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] d;
      d = '0;
      if (c inside {[8'h61:8'h7a]}) begin
         d = c - 8'h61;
         return {1'b1, d[SYM_W-1:0]};
      end
      if (c inside {[8'h30:8'h39]}) begin
         d = c - 8'h30 + 8'd26;
         return {1'b1, d[SYM_W-1:0]};
      end
      return '0;
   endfunction

   // alphabet character at a symbol index
   function automatic logic [CHAR_W-1:0] sym_char(input logic [SYM_W-1:0] idx);
      logic [CHAR_W-1:0] wide;
      wide = {2'b00, idx};
      if (idx < 6'd26) begin
         return 8'h61 + wide;
      end
      return 8'h30 + (wide - 8'd26);
   endfunction

   // fold A-Z to lower case
   function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
      if (c inside {[8'h41:8'h5a]}) begin
         return c + 8'd32;
      end
      return c;
   endfunction

endpackage

[src/pf66_ctrl.sv]
// Sequencer for the Playfair unit: request dispatch, alphabet walk and pair steps.
module pf66_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_kind,
   output logic                     busy,
   input  pf66_pkg::pf66_status_type status,
   output pf66_pkg::pf66_cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_KEY  = 7'b0000010,
      ST_FILL = 7'b0000100,
      ST_TEXT = 7'b0001000,
      ST_MAP  = 7'b0010000,
      ST_SQ   = 7'b0100000,
      ST_EMIT = 7'b1000000
   } state_type;

   state_type                    state_ff, state_in;
   logic [pf66_pkg::SYM_W-1:0]   walk_ff, walk_in;

   assign busy = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      walk_in  = walk_ff;
      cmd      = '0;
      cmd.fill_idx = walk_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               walk_in      = '0;
               case (req_kind)
                  pf66_pkg::REQ_KEY:    state_in = ST_KEY;
                  pf66_pkg::REQ_FINISH: state_in = ST_FILL;
                  pf66_pkg::REQ_TEXT:   state_in = ST_TEXT;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         ST_KEY: begin
            cmd.key_append = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_FILL: begin
            cmd.fill_append = 1'b1;
            if (walk_ff == pf66_pkg::SYM_W'(pf66_pkg::CELLS - 1)) begin
               walk_in  = '0;
               state_in = ST_IDLE;
            end else begin
               walk_in = walk_ff + 1'b1;
            end
         end
         ST_TEXT: begin
            cmd.text_decide = 1'b1;
            state_in = status.text_has_pair ? ST_MAP : ST_IDLE;
         end
         ST_MAP: begin
            cmd.map_read = 1'b1;
            state_in     = ST_SQ;
         end
         ST_SQ: begin
            cmd.sq_read = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.slot_free) begin
               cmd.emit_load = 1'b1;
               if (status.has_second) begin
                  cmd.next_pair = 1'b1;
                  state_in      = ST_MAP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         walk_ff  <= '0;
      end else begin
         state_ff <= state_in;
         walk_ff  <= walk_in;
      end
   end

endmodule

[src/pf66_dpath.sv]
// Datapath for the Playfair unit: square and position memories, pairing and result register.
module pf66_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pf66_pkg::req_payload_type             req_data,
   input  logic                                 csr_write_en,
   input  logic                                 csr_index,
   input  logic [pf66_pkg::CHAR_W-1:0]           csr_wdata,
   input  pf66_pkg::pf66_cmd_type                cmd,
   output pf66_pkg::pf66_status_type             status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output pf66_pkg::rsp_payload_type             rsp_data
);

   localparam int SW = pf66_pkg::SYM_W;
   localparam int CW = pf66_pkg::CHAR_W;
   localparam int RW = pf66_pkg::RC_W;
   localparam logic [RW-1:0] LAST_RC = RW'(pf66_pkg::SIDE - 1);

   // configuration
   logic                decrypt_ff;
   logic [CW-1:0]       pad_ff;

   // square build state
   logic [pf66_pkg::CELLS-1:0] present_ff;
   logic [SW-1:0]       fill_ff;
   logic [RW-1:0]       fill_row_ff, fill_col_ff;

   // memories: cell characters by position, row/col by symbol
   logic [CW-1:0]       square_ff [pf66_pkg::CELLS];
   logic [2*RW-1:0]     posmap_ff [pf66_pkg::CELLS];

   // pairing state
   logic                pend_ff, pend_in;
   logic [CW-1:0]       pchar_ff, pchar_in;
   logic                second_ff, second_in;
   pf66_pkg::req_payload_type req_ff;
   logic [CW-1:0]       op_a_ff, op_a_in, op_b_ff, op_b_in, sec_a_ff, sec_a_in;
   logic                op_last_ff, op_last_in;

   // read data
   logic [2*RW-1:0]     pm0_ff, pm1_ff;
   logic [CW-1:0]       sq0_ff, sq1_ff;

   // result register
   logic                rsp_valid_ff;
   pf66_pkg::rsp_payload_type rsp_data_ff;

   // append path
   logic [SW:0]         key_sym;
   logic                app_ok;
   logic [SW-1:0]       app_idx;
   logic                do_append;

   // lookup and rule logic
   logic [SW:0]         look_a, look_b;
   logic                found_a, found_b, nf;
   logic [RW-1:0]       r1, c1, r2, c2, r1n, c1n, r2n, c2n;
   logic [SW-1:0]       addr0, addr1;

   function automatic logic [RW-1:0] wrap_step(input logic [RW-1:0] v, input logic back);
      if (back) begin
         return (v == '0) ? LAST_RC : v - 1'b1;
      end
      return (v == LAST_RC) ? '0 : v + 1'b1;
   endfunction

   function automatic logic [SW-1:0] cell_addr(input logic [RW-1:0] r, input logic [RW-1:0] c);
      logic [SW-1:0] rw;
      rw = {{(SW-RW){1'b0}}, r};
      return (rw << 2) + (rw << 1) + {{(SW-RW){1'b0}}, c};
   endfunction

   // pick the symbol to append
   always_comb begin
      key_sym = pf66_pkg::sym_lookup(pf66_pkg::to_lower(req_ff.in_char));
      app_ok  = 1'b0;
      app_idx = cmd.fill_idx;
      if (cmd.key_append) begin
         app_ok  = key_sym[SW];
         app_idx = key_sym[SW-1:0];
      end else if (cmd.fill_append) begin
         app_ok  = 1'b1;
      end
      do_append = app_ok && !present_ff[app_idx]
                  && (fill_ff < SW'(pf66_pkg::CELLS));
   end

   // decide pairs for a text request, or step to the second pair
   always_comb begin
      pend_in    = pend_ff;
      pchar_in   = pchar_ff;
      second_in  = second_ff;
      op_a_in    = op_a_ff;
      op_b_in    = op_b_ff;
      op_last_in = op_last_ff;
      sec_a_in   = sec_a_ff;
      if (cmd.text_decide) begin
         second_in = 1'b0;
         if (!pend_ff) begin
            if (req_ff.in_last) begin
               op_a_in    = req_ff.in_char;
               op_b_in    = pad_ff;
               op_last_in = 1'b1;
            end else begin
               pend_in  = 1'b1;
               pchar_in = req_ff.in_char;
            end
         end else if (req_ff.in_char == pchar_ff) begin
            op_a_in    = pchar_ff;
            op_b_in    = pad_ff;
            op_last_in = 1'b0;
            if (req_ff.in_last) begin
               second_in = 1'b1;
               sec_a_in  = req_ff.in_char;
               pend_in   = 1'b0;
               pchar_in  = '0;
            end
         end else begin
            op_a_in    = pchar_ff;
            op_b_in    = req_ff.in_char;
            op_last_in = req_ff.in_last;
            pend_in    = 1'b0;
            pchar_in   = '0;
         end
      end else if (cmd.next_pair) begin
         op_a_in    = sec_a_ff;
         op_b_in    = pad_ff;
         op_last_in = 1'b1;
         second_in  = 1'b0;
      end
   end

   // lookup and cipher rule
   always_comb begin
      look_a  = pf66_pkg::sym_lookup(op_a_ff);
      look_b  = pf66_pkg::sym_lookup(op_b_ff);
      found_a = look_a[SW] && present_ff[look_a[SW-1:0]];
      found_b = look_b[SW] && present_ff[look_b[SW-1:0]];
      nf      = !(found_a && found_b);
      r1 = pm0_ff[2*RW-1:RW];
      c1 = pm0_ff[RW-1:0];
      r2 = pm1_ff[2*RW-1:RW];
      c2 = pm1_ff[RW-1:0];
      r1n = r1;
      r2n = r2;
      c1n = c2;
      c2n = c1;
      if (r1 == r2) begin
         c1n = wrap_step(c1, decrypt_ff);
         c2n = wrap_step(c2, decrypt_ff);
      end else if (c1 == c2) begin
         r1n = wrap_step(r1, decrypt_ff);
         r2n = wrap_step(r2, decrypt_ff);
         c1n = c1;
         c2n = c2;
      end
      addr0 = cell_addr(r1n, c1n);
      addr1 = cell_addr(r2n, c2n);
   end

   // memories and read registers
   always_ff @(posedge clock) begin
      if (do_append) begin
         square_ff[fill_ff]  <= pf66_pkg::sym_char(app_idx);
         posmap_ff[app_idx]  <= {fill_row_ff, fill_col_ff};
      end
      if (cmd.map_read) begin
         pm0_ff <= posmap_ff[look_a[SW-1:0]];
         pm1_ff <= posmap_ff[look_b[SW-1:0]];
      end
      if (cmd.sq_read) begin
         sq0_ff <= square_ff[addr0];
         sq1_ff <= square_ff[addr1];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff <= req_data;
      end
      op_a_ff    <= op_a_in;
      op_b_ff    <= op_b_in;
      op_last_ff <= op_last_in;
      sec_a_ff   <= sec_a_in;
      if (cmd.emit_load) begin
         rsp_data_ff.out_first  <= nf ? op_a_ff : sq0_ff;
         rsp_data_ff.out_second <= nf ? op_b_ff : sq1_ff;
         rsp_data_ff.pair_last  <= op_last_ff;
         rsp_data_ff.not_found  <= nf;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_ff   <= 1'b0;
         pad_ff       <= pf66_pkg::PAD_RESET;
         present_ff   <= '0;
         fill_ff      <= '0;
         fill_row_ff  <= '0;
         fill_col_ff  <= '0;
         pend_ff      <= 1'b0;
         pchar_ff     <= '0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               pf66_pkg::CSR_DECRYPT_MODE: decrypt_ff <= csr_wdata[0];
               pf66_pkg::CSR_PAD_CHAR:     pad_ff     <= csr_wdata;
               default:                    pad_ff     <= pad_ff;
            endcase
         end
         if (do_append) begin
            present_ff[app_idx] <= 1'b1;
            fill_ff             <= fill_ff + 1'b1;
            if (fill_col_ff == LAST_RC) begin
               fill_col_ff <= '0;
               fill_row_ff <= fill_row_ff + 1'b1;
            end else begin
               fill_col_ff <= fill_col_ff + 1'b1;
            end
         end
         pend_ff   <= pend_in;
         pchar_ff  <= pchar_in;
         second_ff <= second_in;
         // load a result, or drop the one taken
         if (cmd.emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.text_has_pair = pend_ff || req_ff.in_last;
   assign status.has_second    = second_ff;
   assign status.slot_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[src/playfair_6x6_digraph_cipher_unit.sv]
// Top level of the 6x6 Playfair digraph cipher unit.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_data  (req_type, in_char, in_last)
//   rsp_      out        rsp_valid/rsp_stall   rsp_data  (out_first, out_second,
//                                                         pair_last, not_found)
//   csr_      in         csr_write_en          csr_index, csr_wdata
//
// A key request appends once; a finish request walks the alphabet, one symbol per cycle.
// A text request decides its pairing, then each digraph takes a position lookup, a square
// read and a result load that waits while a held result is stalled; the two-port memory reads set the digraph steps.
// The result register frees the sequencer while a request waits on rsp_stall; a held
// result stalls only a following digraph. Reset is synchronous and clears the square.
module playfair_6x6_digraph_cipher_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  pf66_pkg::req_payload_type           req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output pf66_pkg::rsp_payload_type           rsp_data,
   input  logic                               csr_write_en,
   input  logic                               csr_index,
   input  logic [pf66_pkg::CHAR_W-1:0]         csr_wdata
);

   pf66_pkg::pf66_cmd_type    cmd;
   pf66_pkg::pf66_status_type status;
   logic                      busy;

   pf66_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.req_type),
      .busy      (busy),
      .status    (status),
      .cmd       (cmd)
   );

   pf66_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

   // take a request only while the sequencer is idle
   assign req_stall = busy;

endmodule

[dv/playfair_6x6_digraph_cipher_unit_test.sv]
// Self-checking testbench for the 6x6 Playfair digraph cipher unit.
module playfair_6x6_digraph_cipher_unit_test;

   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam int         SETTLE_CYCLES = 50;
   localparam int         REPORT_LIMIT  = 10;

   logic                          clock        = 1'b0;
   logic                          reset        = 1'b1;
   logic                          req_valid    = 1'b0;
   logic                          req_stall;
   pf66_pkg::req_payload_type     req_data     = '0;
   logic                          rsp_valid;
   logic                          rsp_stall    = 1'b0;
   pf66_pkg::rsp_payload_type     rsp_data;
   logic                          csr_write_en = 1'b0;
   logic                          csr_index    = pf66_pkg::CSR_DECRYPT_MODE;
   logic [pf66_pkg::CHAR_W-1:0]   csr_wdata    = '0;

   // predictor state: square, placed symbols, held text character, registers
   logic [pf66_pkg::CHAR_W-1:0] square [pf66_pkg::CELLS];
   logic [pf66_pkg::CELLS-1:0]  placed;
   int                          filled;
   logic                        held_valid;
   logic [pf66_pkg::CHAR_W-1:0] held_char;
   logic                        mode_decrypt;
   logic [pf66_pkg::CHAR_W-1:0] pad_value;
   pf66_pkg::rsp_payload_type   expected_digraphs [$];

   // run control and tallies
   bit idle_enable     = 1'b0;
   int hold_off_cycles = 0;
   int request_count   = 0;
   int text_count      = 0;
   int setting_count   = 0;
   int digraph_count   = 0;
   int mismatch_count  = 0;
   int stray_count     = 0;
   int missing_count   = 0;

   playfair_6x6_digraph_cipher_unit uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // end a hung run
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int symbol_of(input logic [pf66_pkg::CHAR_W-1:0] c);
      if (c inside {[8'h61:8'h7a]}) return int'(c) - 8'h61;
      if (c inside {[8'h30:8'h39]}) return 26 + int'(c) - 8'h30;
      return -1;
   endfunction

   // append a symbol at the next free cell unless already placed
   function automatic void place_symbol(input int idx);
      if (idx < 0 || filled >= pf66_pkg::CELLS) return;
      if (placed[idx]) return;
      square[filled] = (idx < 26) ? 8'(8'h61 + idx) : 8'(8'h30 + idx - 26);
      filled++;
      placed[idx] = 1'b1;
   endfunction

   function automatic int find_cell(input logic [pf66_pkg::CHAR_W-1:0] c);
      for (int i = 0; i < filled; i++) begin
         if (square[i] == c) return i;
      end
      return -1;
   endfunction

   // cipher one digraph and queue the expected response
   function automatic void push_digraph(input logic [pf66_pkg::CHAR_W-1:0] a,
                                        input logic [pf66_pkg::CHAR_W-1:0] b,
                                        input logic last);
      int pa, pb, r1, c1, r2, c2, shift_by, t;
      pf66_pkg::rsp_payload_type d;
      pa = find_cell(a);
      pb = find_cell(b);
      d.out_first  = a;
      d.out_second = b;
      d.pair_last  = last;
      d.not_found  = 1'b1;
      if (pa >= 0 && pb >= 0) begin
         d.not_found = 1'b0;
         r1 = pa / pf66_pkg::SIDE;
         c1 = pa % pf66_pkg::SIDE;
         r2 = pb / pf66_pkg::SIDE;
         c2 = pb % pf66_pkg::SIDE;
         shift_by = mode_decrypt ? pf66_pkg::SIDE - 1 : 1;
         if (r1 == r2) begin
            c1 = (c1 + shift_by) % pf66_pkg::SIDE;
            c2 = (c2 + shift_by) % pf66_pkg::SIDE;
         end else if (c1 == c2) begin
            r1 = (r1 + shift_by) % pf66_pkg::SIDE;
            r2 = (r2 + shift_by) % pf66_pkg::SIDE;
         end else begin
            t  = c1;
            c1 = c2;
            c2 = t;
         end
         d.out_first  = square[r1 * pf66_pkg::SIDE + c1];
         d.out_second = square[r2 * pf66_pkg::SIDE + c2];
      end
      expected_digraphs.push_back(d);
   endfunction

   // advance the predictor by one accepted request
   function automatic void predict_digraphs(input pf66_pkg::req_payload_type p);
      logic [pf66_pkg::CHAR_W-1:0] c;
      int i;
      c = p.in_char;
      case (p.req_type)
         pf66_pkg::REQ_KEY: begin
            if (c inside {[8'h41:8'h5a]}) c = c + 8'd32;
            place_symbol(symbol_of(c));
         end
         pf66_pkg::REQ_FINISH: begin
            for (i = 0; i < pf66_pkg::CELLS; i++) place_symbol(i);
         end
         pf66_pkg::REQ_TEXT: begin
            if (!held_valid) begin
               if (p.in_last) begin
                  push_digraph(c, pad_value, 1'b1);
               end else begin
                  held_valid = 1'b1;
                  held_char  = c;
               end
            end else if (c == held_char) begin
               // doubled letter: pad the first, keep the second pending
               push_digraph(held_char, pad_value, 1'b0);
               if (p.in_last) begin
                  push_digraph(c, pad_value, 1'b1);
                  held_valid = 1'b0;
                  held_char  = '0;
               end
            end else begin
               push_digraph(held_char, c, p.in_last);
               held_valid = 1'b0;
               held_char  = '0;
            end
         end
         default: begin
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- drivers

   // offer one request and hold it until accepted
   task automatic send_request(input logic [1:0] kind,
                               input logic [pf66_pkg::CHAR_W-1:0] ch,
                               input logic last);
      pf66_pkg::req_payload_type p;
      p.req_type = kind;
      p.in_char  = ch;
      p.in_last  = last;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_digraphs(p);
      request_count++;
      if (kind == pf66_pkg::REQ_TEXT) text_count++;
   endtask

   task automatic send_pair(input logic [pf66_pkg::CHAR_W-1:0] a,
                            input logic [pf66_pkg::CHAR_W-1:0] b,
                            input logic last);
      send_request(pf66_pkg::REQ_TEXT, a, 1'b0);
      send_request(pf66_pkg::REQ_TEXT, b, last);
   endtask

   // drop valid, wait for every expected response, then let the block settle
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_digraphs.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write both registers; only called while the block is idle
   task automatic apply_setting(input logic decrypt,
                                input logic [pf66_pkg::CHAR_W-1:0] pad);
      csr_write_en <= 1'b1;
      csr_index    <= pf66_pkg::CSR_DECRYPT_MODE;
      csr_wdata    <= {7'd0, decrypt};
      @(posedge clock);
      mode_decrypt = decrypt;
      csr_index    <= pf66_pkg::CSR_PAD_CHAR;
      csr_wdata    <= pad;
      @(posedge clock);
      pad_value = pad;
      csr_write_en <= 1'b0;
      setting_count++;
   endtask

   // receiver: random stall bursts, plus a long hold-off on request
   initial begin : response_stall_driver
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each accepted response with the oldest expected digraph
   initial begin : digraph_checker
      pf66_pkg::rsp_payload_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_digraphs.size() == 0) begin
               stray_count++;
               if (mismatch_count + stray_count <= REPORT_LIMIT)
                  $display("unexpected digraph %h %h last=%b nf=%b", rsp_data.out_first,
                           rsp_data.out_second, rsp_data.pair_last, rsp_data.not_found);
            end else begin
               want = expected_digraphs.pop_front();
               digraph_count++;
               if (rsp_data.out_first !== want.out_first ||
                   rsp_data.out_second !== want.out_second ||
                   rsp_data.pair_last !== want.pair_last ||
                   rsp_data.not_found !== want.not_found) begin
                  mismatch_count++;
                  if (mismatch_count + stray_count <= REPORT_LIMIT)
                     $display("digraph %0d: expected %h %h last=%b nf=%b, got %h %h last=%b nf=%b",
                              digraph_count, want.out_first, want.out_second, want.pair_last,
                              want.not_found, rsp_data.out_first, rsp_data.out_second,
                              rsp_data.pair_last, rsp_data.not_found);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // build the square from key requests; text mid-build only misses the square
   task automatic test_square_build();
      int i;
      logic [pf66_pkg::CHAR_W-1:0] ch;
      send_request(pf66_pkg::REQ_KEY, "K", 1'b0);
      send_request(pf66_pkg::REQ_KEY, "k", 1'b1);
      send_request(pf66_pkg::REQ_KEY, "!", 1'b0);
      send_request(pf66_pkg::REQ_KEY, "7", 1'b0);
      send_request(REQ_UNUSED, "z", 1'b1);
      send_request(pf66_pkg::REQ_KEY, 8'hff, 1'b0);
      send_request(pf66_pkg::REQ_KEY, 8'h00, 1'b1);
      send_request(pf66_pkg::REQ_KEY, "Z", 1'b0);
      // a pending text character survives key requests
      send_request(pf66_pkg::REQ_TEXT, "!", 1'b0);
      send_request(pf66_pkg::REQ_KEY, "q", 1'b0);
      send_request(pf66_pkg::REQ_TEXT, "#", 1'b1);
      send_request(pf66_pkg::REQ_TEXT, "k", 1'b0);
      send_request(pf66_pkg::REQ_TEXT, "?", 1'b1);
      // random key bytes, mostly letters and digits of either case
      for (i = 0; i < 40; i++) begin
         case ($urandom_range(0, 3))
            0:       ch = 8'($urandom_range(8'h61, 8'h7a));
            1:       ch = 8'($urandom_range(8'h41, 8'h5a));
            2:       ch = 8'($urandom_range(8'h30, 8'h39));
            default: ch = 8'($urandom());
         endcase
         send_request(pf66_pkg::REQ_KEY, ch, 1'($urandom()));
      end
      // finish with a text character pending, then poke the full square
      send_request(pf66_pkg::REQ_TEXT, "%", 1'b0);
      send_request(pf66_pkg::REQ_FINISH, 8'($urandom()), 1'b1);
      send_request(pf66_pkg::REQ_KEY, "a", 1'b0);
      send_request(pf66_pkg::REQ_FINISH, 8'($urandom()), 1'b0);
      send_request(pf66_pkg::REQ_TEXT, square[0], 1'b1);
      drain_results();
   endtask

   // row, column and rectangle rules at the square's edges, padding cases
   task automatic test_directed_text();
      send_pair(square[0], square[1], 1'b0);
      send_pair(square[4], square[5], 1'b0);
      send_pair(square[5], square[35], 1'b0);
      send_pair(square[0], square[35], 1'b0);
      send_pair(square[7], square[7], 1'b0);
      send_request(pf66_pkg::REQ_TEXT, square[9], 1'b1);
      send_pair(square[2], square[2], 1'b1);
      send_request(pf66_pkg::REQ_TEXT, square[3], 1'b1);
      send_pair("x", "x", 1'b1);
      send_pair("A", "B", 1'b1);
      send_pair(8'h00, 8'hff, 1'b1);
      drain_results();

      apply_setting(1'b1, pf66_pkg::PAD_RESET);
      send_pair(square[0], square[5], 1'b0);
      send_pair(square[0], square[30], 1'b0);
      send_pair(square[6], square[13], 1'b1);
      drain_results();

      apply_setting(1'b0, 8'h00);
      send_request(pf66_pkg::REQ_TEXT, square[3], 1'b1);
      send_pair(square[8], square[8], 1'b1);
      drain_results();

      apply_setting(1'b1, 8'hff);
      send_request(pf66_pkg::REQ_TEXT, square[3], 1'b1);
      drain_results();

      apply_setting(1'b0, square[20]);
      send_pair(square[20], square[20], 1'b1);
      send_request(pf66_pkg::REQ_TEXT, square[14], 1'b1);
      drain_results();
   endtask

   // random messages under one setting, with ignored requests mixed in
   task automatic test_random_messages(input logic decrypt,
                                       input logic [pf66_pkg::CHAR_W-1:0] pad,
                                       input int budget);
      int start, len, k, pick;
      bit ragged;
      logic last;
      logic [1:0] kind;
      logic [pf66_pkg::CHAR_W-1:0] ch, prev;
      apply_setting(decrypt, pad);
      start = text_count;
      while (text_count - start < budget) begin
         len    = $urandom_range(1, 16);
         ragged = ($urandom_range(0, 9) == 0);
         prev   = square[0];
         for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 19) == 0) begin
               case ($urandom_range(0, 2))
                  0:       kind = pf66_pkg::REQ_KEY;
                  1:       kind = pf66_pkg::REQ_FINISH;
                  default: kind = REQ_UNUSED;
               endcase
               send_request(kind, 8'($urandom()), 1'($urandom()));
            end
            pick = $urandom_range(0, 9);
            if (k > 0 && pick < 2)  ch = prev;
            else if (pick == 2)     ch = 8'($urandom());
            else if (pick == 3)     ch = pad_value;
            else                    ch = square[$urandom_range(0, pf66_pkg::CELLS - 1)];
            // broken messages scatter last marks; every message still closes
            last = (k == len - 1) ? 1'b1 : (ragged ? 1'($urandom()) : 1'b0);
            send_request(pf66_pkg::REQ_TEXT, ch, last);
            prev = ch;
         end
      end
      drain_results();
   endtask

   // fill the block behind a long receiver hold-off, then pause mid-message
   task automatic test_backpressure();
      int k;
      idle_enable = 1'b0;
      hold_off_cycles = 300;
      for (k = 0; k < 40; k++)
         send_request(pf66_pkg::REQ_TEXT, square[$urandom_range(0, pf66_pkg::CELLS - 1)],
                      k % 8 == 7);
      send_request(pf66_pkg::REQ_TEXT, square[11], 1'b0);
      send_request(pf66_pkg::REQ_TEXT, square[12], 1'b0);
      send_request(pf66_pkg::REQ_TEXT, square[17], 1'b0);
      drain_results();
      send_request(pf66_pkg::REQ_TEXT, square[23], 1'b1);
      drain_results();
      idle_enable = 1'b1;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin : test_sequence
      int waited;
      placed       = '0;
      filled       = 0;
      held_valid   = 1'b0;
      held_char    = '0;
      mode_decrypt = 1'b0;
      pad_value    = pf66_pkg::PAD_RESET;
      foreach (square[i]) square[i] = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_enable = 1'b1;
      apply_setting(1'b0, pf66_pkg::PAD_RESET);

      test_square_build();
      test_directed_text();
      test_random_messages(1'b0, pf66_pkg::PAD_RESET, 150);
      test_random_messages(1'b1, pf66_pkg::PAD_RESET, 150);
      test_random_messages(1'b0, square[$urandom_range(0, pf66_pkg::CELLS - 1)], 150);
      test_random_messages(1'b1, 8'h00, 120);
      test_random_messages(1'b0, 8'hff, 120);
      test_random_messages(1'b1, 8'($urandom()), 80);
      test_backpressure();
      // closing stretch runs without gaps on either side
      idle_enable = 1'b0;
      test_random_messages(1'($urandom()), square[$urandom_range(0, pf66_pkg::CELLS - 1)],
                           150);

      // bounded wait for anything still outstanding
      req_valid <= 1'b0;
      for (waited = 0; expected_digraphs.size() > 0 && waited < 5000; waited++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      missing_count = expected_digraphs.size();

      $display("Run covered %0d requests (%0d text) under %0d register settings.",
               request_count, text_count, setting_count);
      $display("Checked %0d digraphs: %0d mismatched, %0d unexpected, %0d missing.",
               digraph_count, mismatch_count, stray_count, missing_count);
      if (mismatch_count == 0 && stray_count == 0 && missing_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
